[rtl/mcbf_pkg.sv]
// ----------------------------------------------------------------------------
// mcbf_pkg
// shared constants, item types and codes for the multi-channel byte fifo
// ----------------------------------------------------------------------------
`default_nettype none

package mcbf_pkg;

   // queue geometry
   localparam int QUEUE_DEPTH = 128;
   localparam int NUM_QUEUES  = 4;
   localparam int MAX_PEEK    = 64;

   // field widths of the items
   localparam int ACT_W  = 3;
   localparam int QSEL_W = 2;
   localparam int BYTE_W = 8;
   localparam int OFS_W  = 8;
   localparam int LEN_W  = 7;
   localparam int STAT_W = 2;
   localparam int CNTF_W = 8;

   // derived widths
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int QIDX_W      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int BYTE_DEPTH  = NUM_QUEUES * QUEUE_DEPTH;
   localparam int BYTE_ADDR_W = (BYTE_DEPTH > 1) ? $clog2(BYTE_DEPTH) : 1;

   // request actions
   typedef enum logic [ACT_W-1:0] {
      ACT_PUT     = 3'd0,
      ACT_GET     = 3'd1,
      ACT_PEEK    = 3'd2,
      ACT_STATUS  = 3'd3,
      ACT_CLR_WP  = 3'd4,
      ACT_CLR_RP  = 3'd5,
      ACT_CLR_CNT = 3'd6
   } act_type;

   // result status codes
   typedef enum logic [STAT_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_FULL     = 2'd1,
      STAT_EMPTY    = 2'd2,
      STAT_PEEK_ERR = 2'd3
   } stat_type;

   // sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_GET,
      S_PEEK
   } state_type;

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [QSEL_W-1:0] queue_sel;
      logic [BYTE_W-1:0] data_in;
      logic [OFS_W-1:0]  peek_offset;
      logic [LEN_W-1:0]  peek_length;
   } req_item_type;

   typedef struct packed {
      logic [QSEL_W-1:0] queue_id;
      logic [BYTE_W-1:0] data_out;
      logic [STAT_W-1:0] status;
      logic [CNTF_W-1:0] fill_count;
      logic [CNTF_W-1:0] free_space;
      logic              is_empty;
      logic              is_full;
      logic              last;
   } rsp_item_type;

   // per-queue descriptor held in the descriptor memory
   typedef struct packed {
      logic [PTR_W-1:0] wp;
      logic [PTR_W-1:0] rp;
      logic [CNT_W-1:0] cnt;
   } desc_type;

   // memory port requests from the sequencer
   typedef struct packed {
      logic                   en;
      logic                   we;
      logic [BYTE_ADDR_W-1:0] addr;
      logic [BYTE_W-1:0]      wdata;
   } byte_req_type;

   typedef struct packed {
      logic              en;
      logic              we;
      logic [QIDX_W-1:0] addr;
      desc_type          wdata;
   } desc_req_type;

endpackage

`default_nettype wire

[rtl/mcbf_ram.sv]
// ----------------------------------------------------------------------------
// mcbf_ram
// single-port synchronous ram, registered read, no reset on contents
// ----------------------------------------------------------------------------
`default_nettype none

module mcbf_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 512
) (
   input  wire logic                                     clock,
   input  wire logic                                     en,
   input  wire logic                                     we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  wire logic [DATA_W-1:0]                        wdata,
   output      logic [DATA_W-1:0]                        rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   // write or registered read
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[rtl/mcbf_ctrl.sv]
// ----------------------------------------------------------------------------
// mcbf_ctrl
// request sequencer: descriptor read-modify-write, byte store access, results
// ----------------------------------------------------------------------------
`default_nettype none

module mcbf_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output      logic                  busy,
   input  wire mcbf_pkg::req_item_type req_item,
   output      logic                  rsp_valid,
   output      mcbf_pkg::rsp_item_type rsp_item,
   output      mcbf_pkg::byte_req_type byte_req,
   input  wire logic [mcbf_pkg::BYTE_W-1:0] byte_rdata,
   output      mcbf_pkg::desc_req_type desc_req,
   input  wire mcbf_pkg::desc_type     desc_rdata
);

   localparam int POS_W = mcbf_pkg::PTR_W + 1;
   localparam int SUM_W = (mcbf_pkg::CNT_W > 9) ? mcbf_pkg::CNT_W : 9;

   mcbf_pkg::state_type    state_ff, state_in;
   mcbf_pkg::req_item_type req_ff, req_in;
   logic [mcbf_pkg::QIDX_W-1:0] q_ff, q_in;
   mcbf_pkg::desc_type     desc_ff, desc_in;
   logic [mcbf_pkg::PTR_W-1:0] peek_pos_ff, peek_pos_in;
   logic [mcbf_pkg::LEN_W-1:0] peek_left_ff, peek_left_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   mcbf_pkg::rsp_item_type rsp_item_ff, rsp_item_in;
   logic [mcbf_pkg::NUM_QUEUES-1:0] desc_vld_ff;
   logic                   rd_vld_ff;

   logic                   accept;
   mcbf_pkg::desc_type     cur_desc;
   logic                   peek_err;
   logic                   put_ok;
   logic                   get_ok;
   logic [SUM_W-1:0]       peek_end;
   logic [POS_W-1:0]       pos_sum;
   logic [mcbf_pkg::PTR_W-1:0] peek_start;

   // queue selector folded onto the queues that exist
   function automatic logic [mcbf_pkg::QIDX_W-1:0] qsel_to_idx(
      input logic [mcbf_pkg::QSEL_W-1:0] sel);
      logic [mcbf_pkg::QIDX_W-1:0] r;
      r = '0;
      for (int i = 0; i < (1 << mcbf_pkg::QSEL_W); i++) begin
         if (sel == mcbf_pkg::QSEL_W'(i)) begin
            r = mcbf_pkg::QIDX_W'(i % mcbf_pkg::NUM_QUEUES);
         end
      end
      return r;
   endfunction

   // step a pointer round the ring
   function automatic logic [mcbf_pkg::PTR_W-1:0] advance(
      input logic [mcbf_pkg::PTR_W-1:0] p);
      logic [mcbf_pkg::PTR_W-1:0] r;
      if (p == mcbf_pkg::PTR_W'(mcbf_pkg::QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   // store address of a byte in a queue
   function automatic logic [mcbf_pkg::BYTE_ADDR_W-1:0] byte_addr(
      input logic [mcbf_pkg::QIDX_W-1:0] q,
      input logic [mcbf_pkg::PTR_W-1:0]  p);
      return mcbf_pkg::BYTE_ADDR_W'(q) * mcbf_pkg::BYTE_ADDR_W'(mcbf_pkg::QUEUE_DEPTH)
           + mcbf_pkg::BYTE_ADDR_W'(p);
   endfunction

   // build a result item from a descriptor
   function automatic mcbf_pkg::rsp_item_type make_rsp(
      input logic [mcbf_pkg::QIDX_W-1:0] q,
      input mcbf_pkg::desc_type          d,
      input logic [mcbf_pkg::BYTE_W-1:0] data,
      input mcbf_pkg::stat_type          stat,
      input logic                        last);
      mcbf_pkg::rsp_item_type r;
      logic                   full;
      full         = (d.cnt >= mcbf_pkg::CNT_W'(mcbf_pkg::QUEUE_DEPTH));
      r.queue_id   = mcbf_pkg::QSEL_W'(q);
      r.data_out   = data;
      r.status     = stat;
      r.fill_count = mcbf_pkg::CNTF_W'(d.cnt);
      r.free_space = full ? '0 :
                     mcbf_pkg::CNTF_W'(mcbf_pkg::CNT_W'(mcbf_pkg::QUEUE_DEPTH) - d.cnt);
      r.is_empty   = (d.cnt == '0);
      r.is_full    = full;
      r.last       = last;
      return r;
   endfunction

   assign busy   = (state_ff != mcbf_pkg::S_IDLE);
   assign accept = start && !busy;

   // descriptor as read, never-written entries read as zero
   assign cur_desc = rd_vld_ff ? desc_rdata : '0;

   // decisions taken on the descriptor
   assign put_ok   = (cur_desc.cnt < mcbf_pkg::CNT_W'(mcbf_pkg::QUEUE_DEPTH));
   assign get_ok   = (cur_desc.cnt != '0);
   assign peek_end = SUM_W'(req_ff.peek_offset) + SUM_W'(req_ff.peek_length);
   assign peek_err = (req_ff.peek_length > mcbf_pkg::LEN_W'(mcbf_pkg::MAX_PEEK))
                  || (SUM_W'(cur_desc.cnt) < peek_end);

   // start of a peek, offset is below the depth whenever the peek is valid
   assign pos_sum    = POS_W'(cur_desc.rp) + POS_W'(req_ff.peek_offset);
   assign peek_start = (pos_sum >= POS_W'(mcbf_pkg::QUEUE_DEPTH)) ?
                       mcbf_pkg::PTR_W'(pos_sum - POS_W'(mcbf_pkg::QUEUE_DEPTH)) :
                       mcbf_pkg::PTR_W'(pos_sum);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mcbf_pkg::S_IDLE: begin
            if (accept) begin
               state_in = mcbf_pkg::S_EVAL;
            end
         end
         mcbf_pkg::S_EVAL: begin
            state_in = mcbf_pkg::S_IDLE;
            if (req_ff.action == mcbf_pkg::ACT_GET && get_ok) begin
               state_in = mcbf_pkg::S_GET;
            end else if (req_ff.action == mcbf_pkg::ACT_PEEK && !peek_err
                         && req_ff.peek_length != '0) begin
               state_in = mcbf_pkg::S_PEEK;
            end
         end
         mcbf_pkg::S_GET: begin
            state_in = mcbf_pkg::S_IDLE;
         end
         mcbf_pkg::S_PEEK: begin
            if (peek_left_ff == mcbf_pkg::LEN_W'(1)) begin
               state_in = mcbf_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = mcbf_pkg::S_IDLE;
         end
      endcase
   end

   // datapath and memory requests
   always_comb begin
      mcbf_pkg::desc_type nd;
      nd           = cur_desc;
      req_in       = req_ff;
      q_in         = q_ff;
      desc_in      = desc_ff;
      peek_pos_in  = peek_pos_ff;
      peek_left_in = peek_left_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in  = rsp_item_ff;
      byte_req     = '0;
      desc_req     = '0;
      case (state_ff)
         mcbf_pkg::S_IDLE: begin
            if (accept) begin
               req_in        = req_item;
               q_in          = qsel_to_idx(req_item.queue_sel);
               desc_req.en   = 1'b1;
               desc_req.addr = q_in;
            end
         end
         mcbf_pkg::S_EVAL: begin
            desc_in      = cur_desc;
            rsp_valid_in = 1'b1;
            rsp_item_in  = make_rsp(q_ff, cur_desc, '0, mcbf_pkg::STAT_OK, 1'b1);
            case (req_ff.action)
               mcbf_pkg::ACT_PUT: begin
                  if (put_ok) begin
                     byte_req.en    = 1'b1;
                     byte_req.we    = 1'b1;
                     byte_req.addr  = byte_addr(q_ff, cur_desc.wp);
                     byte_req.wdata = req_ff.data_in;
                     nd.wp          = advance(cur_desc.wp);
                     nd.cnt         = cur_desc.cnt + 1'b1;
                     desc_req.en    = 1'b1;
                     desc_req.we    = 1'b1;
                     desc_req.addr  = q_ff;
                     desc_req.wdata = nd;
                     rsp_item_in    = make_rsp(q_ff, nd, '0, mcbf_pkg::STAT_OK, 1'b1);
                  end else begin
                     rsp_item_in = make_rsp(q_ff, cur_desc, '0, mcbf_pkg::STAT_FULL, 1'b1);
                  end
               end
               mcbf_pkg::ACT_GET: begin
                  if (get_ok) begin
                     byte_req.en    = 1'b1;
                     byte_req.addr  = byte_addr(q_ff, cur_desc.rp);
                     nd.rp          = advance(cur_desc.rp);
                     nd.cnt         = cur_desc.cnt - 1'b1;
                     desc_req.en    = 1'b1;
                     desc_req.we    = 1'b1;
                     desc_req.addr  = q_ff;
                     desc_req.wdata = nd;
                     desc_in        = nd;
                     rsp_valid_in   = 1'b0;
                  end else begin
                     rsp_item_in = make_rsp(q_ff, cur_desc, '0, mcbf_pkg::STAT_EMPTY, 1'b1);
                  end
               end
               mcbf_pkg::ACT_PEEK: begin
                  if (peek_err) begin
                     rsp_item_in = make_rsp(q_ff, cur_desc, '0,
                                            mcbf_pkg::STAT_PEEK_ERR, 1'b1);
                  end else if (req_ff.peek_length != '0) begin
                     byte_req.en   = 1'b1;
                     byte_req.addr = byte_addr(q_ff, peek_start);
                     peek_pos_in   = advance(peek_start);
                     peek_left_in  = req_ff.peek_length;
                     rsp_valid_in  = 1'b0;
                  end
               end
               mcbf_pkg::ACT_CLR_WP, mcbf_pkg::ACT_CLR_RP, mcbf_pkg::ACT_CLR_CNT: begin
                  if (req_ff.action == mcbf_pkg::ACT_CLR_WP) begin
                     nd.wp = '0;
                  end else if (req_ff.action == mcbf_pkg::ACT_CLR_RP) begin
                     nd.rp = '0;
                  end else begin
                     nd.cnt = '0;
                  end
                  desc_req.en    = 1'b1;
                  desc_req.we    = 1'b1;
                  desc_req.addr  = q_ff;
                  desc_req.wdata = nd;
                  rsp_item_in    = make_rsp(q_ff, nd, '0, mcbf_pkg::STAT_OK, 1'b1);
               end
               default: begin
                  rsp_item_in = make_rsp(q_ff, cur_desc, '0, mcbf_pkg::STAT_OK, 1'b1);
               end
            endcase
         end
         mcbf_pkg::S_GET: begin
            rsp_valid_in = 1'b1;
            rsp_item_in  = make_rsp(q_ff, desc_ff, byte_rdata, mcbf_pkg::STAT_OK, 1'b1);
         end
         mcbf_pkg::S_PEEK: begin
            rsp_valid_in = 1'b1;
            rsp_item_in  = make_rsp(q_ff, desc_ff, byte_rdata, mcbf_pkg::STAT_OK,
                                    peek_left_ff == mcbf_pkg::LEN_W'(1));
            peek_left_in = peek_left_ff - 1'b1;
            if (peek_left_ff > mcbf_pkg::LEN_W'(1)) begin
               byte_req.en   = 1'b1;
               byte_req.addr = byte_addr(q_ff, peek_pos_ff);
               peek_pos_in   = advance(peek_pos_ff);
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mcbf_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         desc_vld_ff  <= '0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (desc_req.en && desc_req.we) begin
            desc_vld_ff[desc_req.addr] <= 1'b1;
         end
         if (desc_req.en && !desc_req.we) begin
            rd_vld_ff <= desc_vld_ff[desc_req.addr];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      q_ff         <= q_in;
      desc_ff      <= desc_in;
      peek_pos_ff  <= peek_pos_in;
      peek_left_ff <= peek_left_in;
      rsp_item_ff  <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

[rtl/multi_channel_byte_fifo_unit.sv]
// ----------------------------------------------------------------------------
// multi_channel_byte_fifo_unit
// four circular byte queues sharing one byte store
// ----------------------------------------------------------------------------
// A request item is taken at a rising edge where start is high and busy is
// low. It names a queue and an action: put, get, peek, status or one of the
// pointer and count clears. Each result item appears on rsp_item for exactly
// one cycle, flagged by rsp_valid; the receiver cannot hold it off. A peek of
// n bytes gives n results on consecutive cycles, the final one marked last.
// The queue descriptor sits in a memory with a registered read; it is read for
// every item and written back by each put, get or clear that changes it. Put,
// status, clear, empty peek and error results are registered from S_EVAL, and
// the next item is taken once the unit is back in S_IDLE. A get adds S_GET for
// the byte store read; a peek of n bytes adds S_PEEK, one store read a cycle.
// Reset clears the descriptor valid flags so every queue reads as empty with
// pointers at zero; the byte store itself is not cleared and needs no pass.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_byte_fifo_unit (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output      logic                   busy,
   input  wire mcbf_pkg::req_item_type req_item,
   output      logic                   rsp_valid,
   output      mcbf_pkg::rsp_item_type rsp_item
);

   mcbf_pkg::byte_req_type          byte_req;
   mcbf_pkg::desc_req_type          desc_req;
   logic [mcbf_pkg::BYTE_W-1:0]     byte_rdata;
   logic [$bits(mcbf_pkg::desc_type)-1:0] desc_rdata_bits;

   // sequencer
   mcbf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item),
      .byte_req   (byte_req),
      .byte_rdata (byte_rdata),
      .desc_req   (desc_req),
      .desc_rdata (mcbf_pkg::desc_type'(desc_rdata_bits))
   );

   // shared byte store
   mcbf_ram #(
      .DATA_W (mcbf_pkg::BYTE_W),
      .DEPTH  (mcbf_pkg::BYTE_DEPTH)
   ) u_byte_ram (
      .clock (clock),
      .en    (byte_req.en),
      .we    (byte_req.we),
      .addr  (byte_req.addr),
      .wdata (byte_req.wdata),
      .rdata (byte_rdata)
   );

   // per-queue pointer and count descriptors
   mcbf_ram #(
      .DATA_W ($bits(mcbf_pkg::desc_type)),
      .DEPTH  (mcbf_pkg::NUM_QUEUES)
   ) u_desc_ram (
      .clock (clock),
      .en    (desc_req.en),
      .we    (desc_req.we),
      .addr  (desc_req.addr),
      .wdata (desc_req.wdata),
      .rdata (desc_rdata_bits)
   );

endmodule

`default_nettype wire

[rtl/mcbf_checker.sv]
// ----------------------------------------------------------------------------
// mcbf_checker
// port-level checks on the byte fifo unit, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module mcbf_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   start,
   input wire logic                   busy,
   input wire logic                   rsp_valid,
   input wire mcbf_pkg::rsp_item_type rsp_item
);

   // a taken item always occupies the unit for the following cycle
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("unit not busy after taking an item");

   // results only come out of work that was under way
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result with no item in progress");

   // a run of peek results has no gaps
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.last |=> rsp_valid)
      else $error("gap inside a multi-result item");

   // a dropped put reports a full queue
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status == mcbf_pkg::STAT_FULL |->
         rsp_item.is_full && rsp_item.free_space == '0)
      else $error("full status without a full queue");

endmodule

bind multi_channel_byte_fifo_unit mcbf_checker u_mcbf_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

`default_nettype wire

[sim/mcbf_result_check.sv]
// ----------------------------------------------------------------------------
// mcbf_result_check
// watches the request and result channels of the multi-channel byte fifo,
// predicts the result items of every accepted request item and compares them
// field by field, in order, with the result items the block produces
// ----------------------------------------------------------------------------

module mcbf_result_check (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  mcbf_pkg::req_item_type req_item,
   input  logic                   rsp_valid,
   input  mcbf_pkg::rsp_item_type rsp_item,
   output int                     fail_count,
   output int                     pending,
   output int                     checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import mcbf_pkg::*;

   // predicted queue state
   logic [BYTE_W-1:0] fifo_bytes [NUM_QUEUES][QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_pos [NUM_QUEUES];
   logic [PTR_W-1:0]  rd_pos [NUM_QUEUES];
   logic [CNT_W-1:0]  held   [NUM_QUEUES];

   rsp_item_type awaited_results [$];
   int           mismatches;
   int           n_checked;

   // queue up one result item with the queue's counts as they now stand
   function automatic void await_result(int q, logic [BYTE_W-1:0] data, stat_type st,
                                        logic fin);
      rsp_item_type r;
      r.queue_id   = QSEL_W'(q);
      r.data_out   = data;
      r.status     = st;
      r.fill_count = held[q];
      r.free_space = CNTF_W'(QUEUE_DEPTH - held[q]);
      r.is_empty   = (held[q] == 0);
      r.is_full    = (held[q] >= QUEUE_DEPTH);
      r.last       = fin;
      awaited_results.push_back(r);
   endfunction

   // apply one request item to the predicted queues and work out its results
   function automatic void predict_fifo_results(req_item_type r);
      int               q;
      int               off;
      int               len;
      logic [PTR_W-1:0] pos;
      q   = r.queue_sel % NUM_QUEUES;
      off = r.peek_offset;
      len = r.peek_length;
      case (r.action)
         ACT_PUT: begin
            if (held[q] < QUEUE_DEPTH) begin
               fifo_bytes[q][wr_pos[q]] = r.data_in;
               wr_pos[q]++;
               held[q]++;
               await_result(q, '0, STAT_OK, 1'b1);
            end else begin
               await_result(q, '0, STAT_FULL, 1'b1);
            end
         end
         ACT_GET: begin
            if (held[q] > 0) begin
               pos = rd_pos[q];
               rd_pos[q]++;
               held[q]--;
               await_result(q, fifo_bytes[q][pos], STAT_OK, 1'b1);
            end else begin
               await_result(q, '0, STAT_EMPTY, 1'b1);
            end
         end
         ACT_PEEK: begin
            if (len > MAX_PEEK || int'(held[q]) < off + len) begin
               await_result(q, '0, STAT_PEEK_ERR, 1'b1);
            end else if (len == 0) begin
               await_result(q, '0, STAT_OK, 1'b1);
            end else begin
               // depth is a power of two, so the pointer width does the wrap
               pos = PTR_W'((rd_pos[q] + off) % QUEUE_DEPTH);
               for (int i = 0; i < len; i++) begin
                  await_result(q, fifo_bytes[q][pos], STAT_OK, i == len - 1);
                  pos++;
               end
            end
         end
         ACT_CLR_WP: begin
            wr_pos[q] = '0;
            await_result(q, '0, STAT_OK, 1'b1);
         end
         ACT_CLR_RP: begin
            rd_pos[q] = '0;
            await_result(q, '0, STAT_OK, 1'b1);
         end
         ACT_CLR_CNT: begin
            held[q] = '0;
            await_result(q, '0, STAT_OK, 1'b1);
         end
         // status and the unused code only report
         default: begin
            await_result(q, '0, STAT_OK, 1'b1);
         end
      endcase
   endfunction

   function automatic void compare_field(string field, int want, int got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endfunction

   // results are compared before new items are predicted: they belong to older items
   always @(posedge clock) begin
      rsp_item_type oldest;
      if (reset) begin
         for (int q = 0; q < NUM_QUEUES; q++) begin
            wr_pos[q] = '0;
            rd_pos[q] = '0;
            held[q]   = '0;
         end
         awaited_results.delete();
         mismatches = 0;
         n_checked  = 0;
      end else begin
         if (rsp_valid) begin
            if (awaited_results.size() == 0) begin
               mismatches++;
               $display("%0t: result item with none outstanding, actual %h", $time, rsp_item);
            end else begin
               oldest = awaited_results.pop_front();
               n_checked++;
               compare_field("queue_id", oldest.queue_id, rsp_item.queue_id);
               compare_field("data_out", oldest.data_out, rsp_item.data_out);
               compare_field("status", oldest.status, rsp_item.status);
               compare_field("fill_count", oldest.fill_count, rsp_item.fill_count);
               compare_field("free_space", oldest.free_space, rsp_item.free_space);
               compare_field("is_empty", oldest.is_empty, rsp_item.is_empty);
               compare_field("is_full", oldest.is_full, rsp_item.is_full);
               compare_field("last", oldest.last, rsp_item.last);
            end
         end
         if (start && !busy) begin
            predict_fifo_results(req_item);
         end
      end
      fail_count    <= mismatches;
      pending       <= awaited_results.size();
      checked_count <= n_checked;
   end

endmodule

[sim/multi_channel_byte_fifo_unit_tb.sv]
// ----------------------------------------------------------------------------
// multi_channel_byte_fifo_unit_tb
// drives request items into the four-queue byte fifo and gives the verdict
// ----------------------------------------------------------------------------
// A directed run covers empty and full queues, every action, the peek error
// cases, stale reads after pointer clears and wrapping peeks; random runs of
// puts, gets, peeks and clears follow under three sender idle profiles. The
// checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------

module multi_channel_byte_fifo_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mcbf_pkg::*;

   localparam int               WATCHDOG_LIMIT = 2000;
   localparam int               ITEM_TARGET    = 160;
   localparam int               PHASE_ITEMS    = 16;
   // code with no defined action, answered as a status request
   localparam logic [ACT_W-1:0] ACT_UNUSED     = 3'd7;

   logic         clock    = 1'b0;
   logic         reset    = 1'b1;
   logic         start    = 1'b0;
   req_item_type req_item = '0;
   logic         busy;
   logic         rsp_valid;
   rsp_item_type rsp_item;

   int fail_count;
   int pending;
   int checked_count;
   int quiet_cycles = 0;
   int idle_pct     = 0;
   int sent_count [8];

   // sender's view of each queue, only to keep reads off never-written bytes
   int plan_wr   [NUM_QUEUES];
   int plan_rd   [NUM_QUEUES];
   int plan_fill [NUM_QUEUES];
   bit byte_written [NUM_QUEUES][QUEUE_DEPTH];

   multi_channel_byte_fifo_unit uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   mcbf_result_check result_check (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_item      (req_item),
      .rsp_valid     (rsp_valid),
      .rsp_item      (rsp_item),
      .fail_count    (fail_count),
      .pending       (pending),
      .checked_count (checked_count)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog: no item moving for too long ends the run
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: nothing moved for %0d cycles", quiet_cycles);
         $display("multi_channel_byte_fifo_unit test failed");
         $finish;
      end
   end

   // true when a get or a good peek would touch a byte never written since reset
   function automatic bit reads_unwritten(req_item_type it);
      int q;
      int len;
      int pos;
      q   = it.queue_sel % NUM_QUEUES;
      len = it.peek_length;
      if (it.action == ACT_GET) begin
         return plan_fill[q] > 0 && !byte_written[q][plan_rd[q]];
      end
      if (it.action == ACT_PEEK && len > 0 && len <= MAX_PEEK
          && it.peek_offset + len <= plan_fill[q]) begin
         for (int i = 0; i < len; i++) begin
            pos = (plan_rd[q] + it.peek_offset + i) % QUEUE_DEPTH;
            if (!byte_written[q][pos]) return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void track_item(req_item_type it);
      int q;
      q = it.queue_sel % NUM_QUEUES;
      sent_count[it.action]++;
      case (it.action)
         ACT_PUT: begin
            if (plan_fill[q] < QUEUE_DEPTH) begin
               byte_written[q][plan_wr[q]] = 1'b1;
               plan_wr[q] = (plan_wr[q] + 1) % QUEUE_DEPTH;
               plan_fill[q]++;
            end
         end
         ACT_GET: begin
            if (plan_fill[q] > 0) begin
               plan_rd[q] = (plan_rd[q] + 1) % QUEUE_DEPTH;
               plan_fill[q]--;
            end
         end
         ACT_CLR_WP:  plan_wr[q] = 0;
         ACT_CLR_RP:  plan_rd[q] = 0;
         ACT_CLR_CNT: plan_fill[q] = 0;
         default: ;
      endcase
   endfunction

   // request items handed over so far
   function automatic int items_sent();
      int n;
      n = 0;
      foreach (sent_count[i]) n += sent_count[i];
      return n;
   endfunction

   // queue holding the most bytes, so filling it to depth takes the fewest puts
   function automatic int fullest_queue();
      int best;
      best = 0;
      for (int q = 1; q < NUM_QUEUES; q++) begin
         if (plan_fill[q] > plan_fill[best]) best = q;
      end
      return best;
   endfunction

   // one request item, after a random sender gap; returns at the accepting edge
   task automatic send(input logic [ACT_W-1:0] act, input int q, input int data,
                       input int off, input int len);
      req_item_type it;
      it.action      = act;
      it.queue_sel   = QSEL_W'(q);
      it.data_in     = BYTE_W'(data);
      it.peek_offset = OFS_W'(off);
      it.peek_length = LEN_W'(len);
      // a read of never-written bytes becomes a put instead
      if (reads_unwritten(it)) it.action = ACT_PUT;
      track_item(it);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // fill a queue to depth, overflow it, then walk the pointers round so peeks wrap
   task automatic fill_and_wrap(input int q);
      while (plan_fill[q] < QUEUE_DEPTH) begin
         send(ACT_PUT, q, $urandom_range(255), $urandom_range(255), $urandom_range(127));
      end
      repeat (2) send(ACT_PUT, q, $urandom_range(255), 0, 0);
      send(ACT_PEEK, q, 0, QUEUE_DEPTH - MAX_PEEK, MAX_PEEK);
      repeat (3) send(ACT_GET, q, 0, 0, 0);
      repeat (3) send(ACT_PUT, q, $urandom_range(255), 0, 0);
      send(ACT_PEEK, q, 0, QUEUE_DEPTH - 8, 8);
      send(ACT_PEEK, q, 0, QUEUE_DEPTH - 2, 2);
   endtask

   // mostly well-formed traffic with random content, some clears and noise
   task automatic random_phase(input int items, input int sender_idle);
      int               done;
      int               q;
      int               kind;
      int               run;
      int               len;
      logic [ACT_W-1:0] act;
      done     = 0;
      idle_pct = sender_idle;
      while (done < items) begin
         q    = $urandom_range(NUM_QUEUES - 1);
         kind = $urandom_range(99);
         run  = 1;
         if (kind < 35) begin
            run = $urandom_range(8, 1);
            repeat (run) begin
               send(ACT_PUT, q, $urandom_range(255), $urandom_range(255),
                    $urandom_range(127));
            end
         end else if (kind < 55) begin
            run = $urandom_range(6, 1);
            repeat (run) begin
               send(ACT_GET, q, $urandom_range(255), $urandom_range(255),
                    $urandom_range(127));
            end
         end else if (kind < 75) begin
            // peek inside what the queue holds
            if (plan_fill[q] == 0) begin
               send(ACT_PEEK, q, $urandom_range(255), 0, 0);
            end else begin
               len = $urandom_range(plan_fill[q] < MAX_PEEK ? plan_fill[q] : MAX_PEEK, 1);
               send(ACT_PEEK, q, $urandom_range(255), $urandom_range(plan_fill[q] - len),
                    len);
            end
         end else if (kind < 83) begin
            act = $urandom_range(1) ? ACT_STATUS : ACT_UNUSED;
            send(act, q, $urandom_range(255), $urandom_range(255), $urandom_range(127));
         end else if (kind < 91) begin
            case ($urandom_range(2))
               0:       act = ACT_CLR_WP;
               1:       act = ACT_CLR_RP;
               default: act = ACT_CLR_CNT;
            endcase
            send(act, q, $urandom_range(255), $urandom_range(255), $urandom_range(127));
         end else begin
            send(ACT_W'($urandom_range(7)), q, $urandom_range(255), $urandom_range(255),
                 $urandom_range(127));
         end
         done += run;
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: empty queue
      idle_pct = 12;
      send(ACT_STATUS, 0, 0, 0, 0);
      send(ACT_GET, 0, 0, 0, 0);
      send(ACT_PEEK, 0, 0, 0, 0);
      send(ACT_PEEK, 0, 0, 0, 1);
      // byte extremes, exact-fit peeks and the peek error cases
      send(ACT_PUT, 3, 8'h00, 0, 0);
      send(ACT_PUT, 3, 8'hFF, 0, 0);
      send(ACT_PUT, 3, 8'hA5, 0, 0);
      send(ACT_PUT, 3, 8'h5A, 0, 0);
      send(ACT_PEEK, 3, 0, 0, 4);
      send(ACT_PEEK, 3, 0, 2, 2);
      send(ACT_PEEK, 3, 0, 255, 1);
      send(ACT_PEEK, 3, 0, 0, 127);
      send(ACT_PEEK, 3, 0, 0, MAX_PEEK);
      send(ACT_GET, 3, 0, 0, 0);
      send(ACT_UNUSED, 2, 0, 0, 0);
      // read pointer clear makes a get return a stale byte again
      send(ACT_PUT, 2, 8'h3C, 0, 0);
      send(ACT_PUT, 2, 8'hC3, 0, 0);
      send(ACT_GET, 2, 0, 0, 0);
      send(ACT_CLR_RP, 2, 0, 0, 0);
      send(ACT_GET, 2, 0, 0, 0);
      // write pointer and count clears
      send(ACT_CLR_WP, 2, 0, 0, 0);
      send(ACT_PUT, 1, 8'h81, 0, 0);
      send(ACT_CLR_CNT, 1, 0, 0, 0);
      send(ACT_GET, 1, 0, 0, 0);

      // random traffic under three sender idle profiles, topped up to the target
      random_phase(PHASE_ITEMS, 12);
      random_phase(PHASE_ITEMS, 69);
      idle_pct = 0;
      fill_and_wrap(fullest_queue());
      random_phase((items_sent() < ITEM_TARGET - PHASE_ITEMS) ?
                   ITEM_TARGET - items_sent() : PHASE_ITEMS, 0);
      start <= 1'b0;

      // drain
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("sent %0d put, %0d get, %0d peek, %0d status, %0d clear items",
               sent_count[ACT_PUT], sent_count[ACT_GET], sent_count[ACT_PEEK],
               sent_count[ACT_STATUS] + sent_count[ACT_UNUSED],
               sent_count[ACT_CLR_WP] + sent_count[ACT_CLR_RP] + sent_count[ACT_CLR_CNT]);
      $display("%0d result items checked, one queue filled to depth and peeked round the wrap",
               checked_count);
      if (fail_count == 0) begin
         $display("multi_channel_byte_fifo_unit test passed");
      end else begin
         $display("multi_channel_byte_fifo_unit test failed");
      end
      $finish;
   end

endmodule
